@@ hdl/gbp_pkg.sv @@
package gbp_pkg;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } pixel_t;

  // config register indexes
  localparam logic [1:0] RegIntensity = 2'd0;
  localparam logic [1:0] RegMode      = 2'd1;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 7;

  // gray method codes; every other code selects luma
  localparam logic [1:0] ModeLuma  = 2'd0;
  localparam logic [1:0] ModeAvg   = 2'd1;
  localparam logic [1:0] ModeLight = 2'd2;

  localparam logic [6:0] FullAmt      = 7'd100;
  localparam logic [6:0] IntensityRst = 7'd100;

  // BT.601 weights over 1000
  localparam logic [8:0] WLumaR = 9'd299;
  localparam logic [9:0] WLumaG = 10'd587;
  localparam logic [6:0] WLumaB = 7'd114;

  // reciprocals, exact over the reachable ranges
  // x/1000 = (x>>3)/125 ; (y*33555)>>22 for y < 32768
  localparam logic [15:0] RecipLuma = 16'd33555;
  // x/3 = (x*683)>>11 for x <= 765
  localparam logic [9:0]  RecipAvg  = 10'd683;
  // x/100 = (x*5243)>>19 for x <= 25500
  localparam logic [12:0] RecipPct  = 13'd5243;

endpackage

@@ hdl/gbp_gray.sv @@
module gbp_gray
  import gbp_pkg::*;
(
  input  logic       clk_i,
  input  logic [1:0] mode_i,
  input  logic [7:0] r_i,
  input  logic [7:0] g_i,
  input  logic [7:0] b_i,
  output logic [7:0] gray_o
);

  logic [17:0] luma_sum_d, luma_sum_q;
  logic [9:0]  avg_sum_d, avg_sum_q;
  logic [8:0]  lite_sum_d, lite_sum_q;
  logic [7:0]  max_rg, min_rg, max_c, min_c;
  logic [30:0] luma_prod;
  logic [19:0] avg_prod;
  logic [7:0]  gray_d, gray_q;

  // stage 1: weighted sums and extremes
  always_comb begin
    max_rg     = (r_i > g_i) ? r_i : g_i;
    min_rg     = (r_i < g_i) ? r_i : g_i;
    max_c      = (max_rg > b_i) ? max_rg : b_i;
    min_c      = (min_rg < b_i) ? min_rg : b_i;
    luma_sum_d = 18'(r_i) * 18'(WLumaR) + 18'(g_i) * 18'(WLumaG) + 18'(b_i) * 18'(WLumaB);
    avg_sum_d  = 10'(r_i) + 10'(g_i) + 10'(b_i);
    lite_sum_d = 9'(max_c) + 9'(min_c);
  end

  always_ff @(posedge clk_i) begin
    luma_sum_q <= luma_sum_d;
    avg_sum_q  <= avg_sum_d;
    lite_sum_q <= lite_sum_d;
  end

  // stage 2: divide and select
  always_comb begin
    luma_prod = 31'(luma_sum_q[17:3]) * 31'(RecipLuma);
    avg_prod  = 20'(avg_sum_q) * 20'(RecipAvg);
    case (mode_i)
      ModeAvg:   gray_d = avg_prod[18:11];
      ModeLight: gray_d = lite_sum_q[8:1];
      default:   gray_d = luma_prod[29:22];
    endcase
  end

  always_ff @(posedge clk_i) begin
    gray_q <= gray_d;
  end

  assign gray_o = gray_q;

endmodule

@@ hdl/gbp_mix.sv @@
module gbp_mix
  import gbp_pkg::*;
(
  input  logic       clk_i,
  input  logic [7:0] gray_i,
  input  logic [7:0] chan_i,
  input  logic [6:0] amt_i,
  input  logic [6:0] inv_i,
  output logic [7:0] mix_o
);

  logic [14:0] prod_d, prod_q;
  logic [27:0] quot;

  // stage 3: weighted blend numerator, at most 25500
  assign prod_d = 15'(gray_i) * 15'(amt_i) + 15'(chan_i) * 15'(inv_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // stage 4: divide by 100
  assign quot  = 28'(prod_q) * 28'(RecipPct);
  assign mix_o = quot[26:19];

endmodule

@@ hdl/grayscale_blend_pixel_core.sv @@
// Throughput: one item per cycle; busy_o is never raised.
// Pipeline: sums, gray divide/select, blend multiply, divide by 100 and output.
// The receiver cannot stall; valid_o pulses for one cycle per item.
// Reset clears the valid pipeline, intensity to 100 and mode to luma.
module grayscale_blend_pixel_core
  import gbp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [31:0]         pixel_in_i,
  output logic                valid_o,
  output logic [31:0]         pixel_out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [6:0] intensity_q;
  logic [1:0] mode_q;
  logic [6:0] amt;
  logic [6:0] inv;
  logic [3:0] vld_d, vld_q;
  pixel_t     pix_q [3];
  pixel_t     pix_in;
  pixel_t     pix_out_d, pix_out_q;
  logic [7:0] gray;
  logic [7:0] mix_r, mix_g, mix_b;

  assign pix_in = pixel_in_i;
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      intensity_q <= IntensityRst;
      mode_q      <= ModeLuma;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegIntensity: intensity_q <= cfg_data_i;
        RegMode:      mode_q      <= cfg_data_i[1:0];
        default:      ;
      endcase
    end
  end

  // zero and out-of-range intensity mean full gray
  assign amt = (intensity_q == 7'd0 || intensity_q > FullAmt) ? FullAmt : intensity_q;
  assign inv = FullAmt - amt;

  assign vld_d = {vld_q[2:0], start_i & ~busy_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q[0]  <= pix_in;
    pix_q[1]  <= pix_q[0];
    pix_q[2]  <= pix_q[1];
    pix_out_q <= pix_out_d;
  end

  gbp_gray u_gray (
    .clk_i  (clk_i),
    .mode_i (mode_q),
    .r_i    (pix_in.r),
    .g_i    (pix_in.g),
    .b_i    (pix_in.b),
    .gray_o (gray)
  );

  gbp_mix u_mix_r (
    .clk_i  (clk_i),
    .gray_i (gray),
    .chan_i (pix_q[1].r),
    .amt_i  (amt),
    .inv_i  (inv),
    .mix_o  (mix_r)
  );

  gbp_mix u_mix_g (
    .clk_i  (clk_i),
    .gray_i (gray),
    .chan_i (pix_q[1].g),
    .amt_i  (amt),
    .inv_i  (inv),
    .mix_o  (mix_g)
  );

  gbp_mix u_mix_b (
    .clk_i  (clk_i),
    .gray_i (gray),
    .chan_i (pix_q[1].b),
    .amt_i  (amt),
    .inv_i  (inv),
    .mix_o  (mix_b)
  );

  // transparent pixels pass through untouched
  always_comb begin
    if (pix_q[2].a == 8'd0) begin
      pix_out_d = pix_q[2];
    end else begin
      pix_out_d.a = pix_q[2].a;
      pix_out_d.b = mix_b;
      pix_out_d.g = mix_g;
      pix_out_d.r = mix_r;
    end
  end

  assign valid_o     = vld_q[3];
  assign pixel_out_o = pix_out_q;

`ifndef ASSERT_OFF
  a_item_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##4 valid_o)
    else $error("accepted item produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i |-> ##4 !valid_o)
    else $error("result without an accepted item");

  a_alpha_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##4 (pixel_out_o[31:24] == $past(pixel_in_i[31:24], 4)))
    else $error("alpha changed");

  a_transparent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && pixel_in_i[31:24] == 8'd0) |-> ##4 (pixel_out_o == $past(pixel_in_i, 4)))
    else $error("transparent pixel modified");

  a_full_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && amt == FullAmt && pixel_out_o[31:24] != 8'd0) |->
      (pixel_out_o[7:0] == pixel_out_o[15:8] && pixel_out_o[15:8] == pixel_out_o[23:16]))
    else $error("channels differ at full intensity");
`endif

endmodule

@@ test/grayscale_blend_pixel_core_test.sv @@
`timescale 1ns / 100ps

module grayscale_blend_pixel_core_test;
  import gbp_pkg::*;

  localparam logic [1:0] ModeLumaAlt = 2'd3;
  localparam logic [1:0] RegSpareA   = 2'd2;
  localparam logic [1:0] RegSpareB   = 2'd3;
  localparam int         Latency     = 4;
  localparam int         NumPhases   = 10;
  localparam int         PhaseItems  = 100;

  class pixel_scoreboard;
    logic [31:0] expected_q[$];
    logic [6:0]  intensity;
    logic [1:0]  mode;
    int          errors;

    function new();
      intensity = IntensityRst;
      mode = ModeLuma;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [6:0] data);
      case (idx)
        RegIntensity: intensity = data;
        RegMode:      mode = data[1:0];
        default:      ;
      endcase
    endfunction

    function logic [31:0] gray_blend(pixel_t p);
      int r, g, b, amt, gray, hi, lo;
      pixel_t q;
      if (p.a == 8'd0) return p;
      r = p.r;
      g = p.g;
      b = p.b;
      amt = (intensity == 7'd0 || intensity > FullAmt) ? 100 : int'(intensity);
      case (mode)
        ModeAvg: gray = (r + g + b) / 3;
        ModeLight: begin
          hi = (r > g) ? r : g;
          hi = (hi > b) ? hi : b;
          lo = (r < g) ? r : g;
          lo = (lo < b) ? lo : b;
          gray = (hi + lo) / 2;
        end
        default: gray = (r * 299 + g * 587 + b * 114) / 1000;
      endcase
      if (amt < 100) begin
        r = (gray * amt + r * (100 - amt)) / 100;
        g = (gray * amt + g * (100 - amt)) / 100;
        b = (gray * amt + b * (100 - amt)) / 100;
      end else begin
        r = gray;
        g = gray;
        b = gray;
      end
      q.a = p.a;
      q.r = 8'(r);
      q.g = 8'(g);
      q.b = 8'(b);
      return q;
    endfunction

    function void note_pixel(logic [31:0] p);
      expected_q.push_back(gray_blend(p));
    endfunction

    task report(string msg);
      $display("%0t: mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_pixel(logic [31:0] got);
      logic [31:0] want;
      if (expected_q.size() == 0) begin
        report($sformatf("pixel_out %h with no item pending", got));
      end else begin
        want = expected_q.pop_front();
        if (got !== want) report($sformatf("pixel_out %h, expected %h", got, want));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [31:0] pixel_in_i = '0;
  logic        valid_o;
  logic [31:0] pixel_out_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [6:0]  cfg_data_i = '0;

  pixel_scoreboard sb = new();

  grayscale_blend_pixel_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .pixel_in_i (pixel_in_i),
    .valid_o    (valid_o),
    .pixel_out_o(pixel_out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note_pixel(pixel_in_i);
      if (valid_o) sb.check_pixel(pixel_out_o);
    end
  end

  task send_pixel(logic [31:0] p, bit idle_on);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    pixel_in_i <= p;
    do @(posedge clk_i); while (busy_o);
  endtask

  task drain();
    start_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task write_reg(logic [1:0] idx, logic [6:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  function logic [31:0] rand_pixel();
    pixel_t p;
    p = $urandom();
    case ($urandom_range(0, 7))
      0: p.a = 8'd0;
      1: begin
        p.r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      2: begin
        p.g = p.r;
        p.b = p.r;
      end
      default: ;
    endcase
    return p;
  endfunction

  logic [31:0] directed_px[] = '{
    32'h00000000, 32'hFFFFFFFF, 32'h00FFFFFF, 32'h00123456, 32'h01000000,
    32'hFF0000FF, 32'hFF00FF00, 32'hFFFF0000, 32'h80FFFFFF, 32'hFF010203,
    32'h7F00FF80, 32'h01FEFDFC
  };

  logic [6:0] phase_intensity[NumPhases] = '{
    7'd0, 7'd127, 7'd101, 7'd1, 7'd50, 7'd99, 7'd100, 7'd37, 7'd64, 7'd0
  };

  logic [6:0] phase_mode[NumPhases] = '{
    {5'd0, ModeAvg}, {5'h1F, ModeLight}, {5'd0, ModeLumaAlt}, {5'd0, ModeAvg},
    {5'd0, ModeLight}, {5'h15, ModeLuma}, {5'h1F, ModeAvg}, {5'd0, ModeLuma},
    {5'h0A, ModeLight}, {5'h1F, ModeLumaAlt}
  };

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: luma at full intensity
    foreach (directed_px[i]) send_pixel(directed_px[i], (i % 2) == 1);

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      write_reg(RegMode, phase_mode[ph]);
      write_reg(RegIntensity, phase_intensity[ph]);
      // writes to unused indexes must leave the config alone
      write_reg((ph % 2) ? RegSpareA : RegSpareB, 7'($urandom()));
      for (int n = 0; n < PhaseItems; n++) send_pixel(rand_pixel(), (ph % 3) != 2);
    end

    drain();
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d items never produced a result", sb.expected_q.size()));
    if (sb.errors == 0) begin
      $display("grayscale_blend_pixel_core_test OK");
    end else begin
      $display("grayscale_blend_pixel_core_test NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("grayscale_blend_pixel_core_test NOT OK");
    $finish;
  end

endmodule
